FILE: hdl/skht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skht_pkg;

    localparam logic [1:0] FUNC_FIND   = 2'd0;
    localparam logic [1:0] FUNC_CREATE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_CREATED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
    // prime is 2^40 + 0x1b3
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] key_byte;
        logic       last;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] slot;
        logic [6:0] entries_used;
    } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/string_key_hash_table.sv
// string key hash table, fixed capacity, linear probing on 64-bit fnv-1a
//
// request channel: req is taken when start is high and busy is low. a key is
// sent one byte per transaction; last closes it. busy stays low while bytes
// that do not close a key are taken. a clear transaction (func clear)
// answers in the next cycle.
// result channel: done is high for one cycle with rsp; the receiver cannot
// stall, so every result must be taken in that cycle.
// after a closing byte the stored length of each probed slot is read and
// tested; if it matches each key byte is read and compared; a create reads and
// writes each key byte; then the result is registered. the compare and copy
// walk one byte a step through the key and slot byte memories, which have a
// single read port each; at load below one half a probe visits few slots.
// busy is high from the closing byte until the result cycle.
// reset empties every slot at once (per-slot valid flops) and restarts the key.
// entries_used reports occupied slots after the request; creates are refused
// with status full once twice the count reaches the slot count.
`timescale 1ns / 1ps
`default_nettype none

module string_key_hash_table #(
    parameter int TABLE_SLOTS   = 64,
    parameter int MAX_KEY_BYTES = 255
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  skht_pkg::req_t      req,
    output logic                done,
    output skht_pkg::rsp_t      rsp
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int LW = $clog2(MAX_KEY_BYTES + 1);
    localparam int JW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int AW = $clog2(TABLE_SLOTS * MAX_KEY_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_TEST,
        S_CMP_RD,
        S_CMP_CHK,
        S_COPY_RD,
        S_COPY_WR
    } state_t;

    state_t          state_reg;
    logic [63:0]     hash_reg;
    logic [LW-1:0]   key_len_reg;
    logic [1:0]      func_reg;
    logic [SW-1:0]   idx_reg;
    logic [CW-1:0]   probes_reg;
    logic [LW-1:0]   j_reg;
    logic [CW-1:0]   count_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic            done_reg;
    skht_pkg::rsp_t  rsp_reg;

    logic [7:0]      kb_mem [MAX_KEY_BYTES];
    logic [7:0]      sk_mem [TABLE_SLOTS * MAX_KEY_BYTES];
    logic [LW-1:0]   len_mem [TABLE_SLOTS];
    logic [7:0]      kb_q;
    logic [7:0]      sk_q;
    logic [LW-1:0]   len_q;

    logic            accept;
    logic            kb_we;
    logic            sk_we;
    logic            len_we;
    logic [63:0]     hash_x;
    logic [63:0]     hash_next;
    logic [AW-1:0]   sk_addr;
    logic [SW-1:0]   idx_wrap;
    logic            j_at_end;
    logic            table_half;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    assign hash_x    = hash_reg ^ {56'd0, req.key_byte};
    assign hash_next = (hash_x << skht_pkg::FNV_PRIME_SHIFT) + hash_x * skht_pkg::FNV_PRIME_LO;

    assign kb_we = accept && (req.func != skht_pkg::FUNC_CLEAR)
                   && (key_len_reg < LW'(MAX_KEY_BYTES));
    assign sk_we  = (state_reg == S_COPY_WR);
    assign len_we = sk_we && j_at_end;

    assign sk_addr    = AW'(idx_reg) * AW'(MAX_KEY_BYTES) + AW'(j_reg);
    assign idx_wrap   = (idx_reg == SW'(TABLE_SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign j_at_end   = (j_reg + 1'b1 == key_len_reg);
    assign table_half = ({count_reg, 1'b0} >= (CW + 1)'(TABLE_SLOTS));

    always_ff @(posedge clk)
    begin
        if (kb_we)
        begin
            kb_mem[key_len_reg[JW-1:0]] <= req.key_byte;
        end
        kb_q <= kb_mem[j_reg[JW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (sk_we)
        begin
            sk_mem[sk_addr] <= kb_q;
        end
        sk_q <= sk_mem[sk_addr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[idx_reg] <= key_len_reg;
        end
        len_q <= len_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hash_reg    <= skht_pkg::FNV_BASIS;
            key_len_reg <= '0;
            func_reg    <= skht_pkg::FUNC_FIND;
            idx_reg     <= '0;
            probes_reg  <= '0;
            j_reg       <= '0;
            count_reg   <= '0;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
            rsp_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.func == skht_pkg::FUNC_CLEAR)
                        begin
                            valid_reg   <= '0;
                            count_reg   <= '0;
                            hash_reg    <= skht_pkg::FNV_BASIS;
                            key_len_reg <= '0;
                            done_reg    <= 1'b1;
                            rsp_reg     <= '{skht_pkg::ST_CLEARED, 6'd0, 7'd0};
                        end
                        else
                        begin
                            logic [63:0]   h;
                            logic [LW-1:0] klen;
                            h = hash_reg;
                            klen = key_len_reg;
                            if (kb_we)
                            begin
                                h = hash_next;
                                klen = key_len_reg + 1'b1;
                            end
                            if (req.last)
                            begin
                                hash_reg <= skht_pkg::FNV_BASIS;
                                if (req.func == skht_pkg::FUNC_FIND
                                    || req.func == skht_pkg::FUNC_CREATE)
                                begin
                                    key_len_reg <= klen;
                                    func_reg    <= req.func;
                                    idx_reg     <= h[SW-1:0] & SW'(TABLE_SLOTS - 1);
                                    probes_reg  <= '0;
                                    state_reg   <= S_LEN;
                                end
                                else
                                begin
                                    key_len_reg <= '0;
                                end
                            end
                            else
                            begin
                                hash_reg    <= h;
                                key_len_reg <= klen;
                            end
                        end
                    end
                end
                S_LEN:
                begin
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    priority if (!valid_reg[idx_reg])
                    begin
                        // empty slot ends the probe
                        j_reg <= '0;
                        if (func_reg == skht_pkg::FUNC_FIND)
                        begin
                            done_reg    <= 1'b1;
                            rsp_reg     <= '{skht_pkg::ST_NOT_FOUND, 6'd0, 7'(count_reg)};
                            key_len_reg <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else if (table_half)
                        begin
                            done_reg    <= 1'b1;
                            rsp_reg     <= '{skht_pkg::ST_FULL, 6'd0, 7'(count_reg)};
                            key_len_reg <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_COPY_RD;
                        end
                    end
                    else if (len_q == key_len_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_CMP_RD;
                    end
                    else
                    begin
                        // length mismatch: step to the next slot
                        j_reg <= '0;
                        if (probes_reg + 1'b1 == CW'(TABLE_SLOTS))
                        begin
                            done_reg    <= 1'b1;
                            rsp_reg     <= (func_reg == skht_pkg::FUNC_FIND)
                                ? '{skht_pkg::ST_NOT_FOUND, 6'd0, 7'(count_reg)}
                                : '{skht_pkg::ST_FULL, 6'd0, 7'(count_reg)};
                            key_len_reg <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            probes_reg <= probes_reg + 1'b1;
                            idx_reg    <= idx_wrap;
                            state_reg  <= S_LEN;
                        end
                    end
                end
                S_CMP_RD:
                begin
                    state_reg <= S_CMP_CHK;
                end
                S_CMP_CHK:
                begin
                    priority if (kb_q != sk_q)
                    begin
                        if (probes_reg + 1'b1 == CW'(TABLE_SLOTS))
                        begin
                            done_reg    <= 1'b1;
                            rsp_reg     <= (func_reg == skht_pkg::FUNC_FIND)
                                ? '{skht_pkg::ST_NOT_FOUND, 6'd0, 7'(count_reg)}
                                : '{skht_pkg::ST_FULL, 6'd0, 7'(count_reg)};
                            key_len_reg <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            probes_reg <= probes_reg + 1'b1;
                            idx_reg    <= idx_wrap;
                            state_reg  <= S_LEN;
                        end
                    end
                    else if (j_at_end)
                    begin
                        done_reg    <= 1'b1;
                        rsp_reg     <= '{skht_pkg::ST_FOUND, 6'(idx_reg), 7'(count_reg)};
                        key_len_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_CMP_RD;
                    end
                end
                S_COPY_RD:
                begin
                    state_reg <= S_COPY_WR;
                end
                S_COPY_WR:
                begin
                    if (j_at_end)
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        count_reg   <= count_reg + 1'b1;
                        done_reg    <= 1'b1;
                        rsp_reg     <= '{skht_pkg::ST_CREATED, 6'(idx_reg),
                                         7'(count_reg + 1'b1)};
                        key_len_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_COPY_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result while a probe is still running");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({count_reg, 1'b0} <= (CW + 1)'(TABLE_SLOTS) + (CW + 1)'(1)))
        else $error("entry count passed half the table");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rsp_reg.status == skht_pkg::ST_FOUND
            || rsp_reg.status == skht_pkg::ST_CREATED
            || rsp_reg.status == skht_pkg::ST_NOT_FOUND
            || rsp_reg.status == skht_pkg::ST_FULL
            || rsp_reg.status == skht_pkg::ST_CLEARED))
        else $error("undefined status code");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == skht_pkg::ST_CLEARED)
            |-> (count_reg == '0 && valid_reg == '0))
        else $error("table not empty after clear");

    a_create_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY_WR && j_at_end) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("create did not bump the entry count");
`endif

endmodule

`default_nettype wire
